### hdl/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg: shared definitions for the streaming substring finder
// Register indexes, default sizes, the cell control word and the ASCII
// case-folding function used by the top level and by every cell.
// ----------------------------------------------------------------------------
package ssf_pkg;

    localparam int PATTERN_MAX_DEF   = 8;
    localparam int POSITION_BITS_DEF = 16;

    // Fixed field widths of the ports and of the length register
    localparam int CHAR_W        = 8;
    localparam int MATCH_START_W = 16;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;
    localparam int LENGTH_REG_W  = 4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CASE_EXACT     = 2'd2;

    // Broadcast from the top level to every cell of the chain
    typedef struct packed {
        logic              advance;     // take the current text byte
        logic              clear;       // drop all partial matches
        logic              case_exact;  // 1: no folding of the pattern byte
        logic [CHAR_W-1:0] text_char;   // already folded text byte
    } ssf_cell_ctrl_t;

    // Fold ASCII upper case to lower case unless exact compare is selected
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                     input logic exact);
        logic [CHAR_W-1:0] r;
        r = c;
        if (!exact && (c inside {[8'h41:8'h5A]})) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

### hdl/ssf_cell.sv
// ----------------------------------------------------------------------------
// ssf_cell: one position of the partial-match chain
// Holds one partial-match bit: set when the last k+1 text bytes equal the
// first k+1 pattern bytes. Takes the bit of its left neighbor each byte.
// ----------------------------------------------------------------------------
module ssf_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ssf_pkg::ssf_cell_ctrl_t        ctrl,
    input  logic                           active,       // cell lies inside pattern length
    input  logic [ssf_pkg::CHAR_W-1:0]     pattern_char,
    input  logic                           prev_match,   // neighbor's registered bit
    output logic                           match_next,   // bit for the current byte
    output logic                           match_reg
);

    logic char_equal;

    assign char_equal = (ssf_pkg::fold_char(pattern_char, ctrl.case_exact) == ctrl.text_char);
    assign match_next = prev_match & active & char_equal;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (ctrl.clear) begin
            match_reg <= 1'b0;
        end else if (ctrl.advance) begin
            match_reg <= match_next;
        end
    end

endmodule

### hdl/streaming_substring_finder.sv
// ----------------------------------------------------------------------------
// streaming_substring_finder: first-occurrence search of a short pattern
// Text bytes stream in one word at a time, the final byte of a text marked
// by s_text_last. The block reports the start of the first occurrence of a
// pattern of up to PATTERN_MAX bytes (exact or ASCII case-insensitive), or,
// on the last byte of a text without a match, one not-found word; then it
// clears for the next text. An empty pattern matches at position 0. The
// position counter saturates at 2^POSITION_BITS-1 and a match completing
// on a byte seen at saturation is not reported. Overlapping candidates are
// all tracked by a chain of PATTERN_MAX cells, each holding one partial-
// match bit and passing it to its neighbor every byte. One text byte is
// taken per clock cycle while the result slot is free or being drained;
// a result enters the output register in the cycle after the byte causing it.
// Configuration writes take effect at once and are accepted every cycle.
// ----------------------------------------------------------------------------
module streaming_substring_finder #(
    parameter int PATTERN_MAX   = ssf_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = ssf_pkg::POSITION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ssf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ssf_pkg::CFG_DATA_W-1:0]      cfg_data,
    // text input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ssf_pkg::CHAR_W-1:0]          s_text_char,
    input  logic                                s_text_last,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_match_found,
    output logic [ssf_pkg::MATCH_START_W-1:0]   m_match_start
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // configuration registers
    logic [ssf_pkg::CFG_DATA_W-1:0]   pattern_bytes_reg;
    logic [ssf_pkg::LENGTH_REG_W-1:0] pattern_length_reg;
    logic                             case_exact_reg;

    // search state
    logic [PATTERN_MAX-1:0]   partial_reg;
    logic [PATTERN_MAX-1:0]   partial_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic                     found_reg;
    logic                     found_next;

    // output register
    logic                                m_valid_reg;
    logic                                m_valid_next;
    logic                                m_match_found_reg;
    logic [ssf_pkg::MATCH_START_W-1:0]   m_match_start_reg;

    logic                            accept;
    logic [LEN_W-1:0]                len_eff;
    logic                            len_zero;
    logic [PATTERN_MAX-1:0]          cell_active;
    logic                            tail_hit;
    logic                            pos_sat;
    logic                            hit;
    logic                            emit;
    logic [POSITION_BITS-1:0]        start_pos;
    logic [POSITION_BITS+ssf_pkg::MATCH_START_W-1:0] start_ext;
    ssf_pkg::ssf_cell_ctrl_t         cell_ctrl;

    // ------------------------------------------------------------------
    // Configuration: always ready, writes land at once
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
            case_exact_reg     <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ssf_pkg::CFG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_data;
                ssf_pkg::CFG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[ssf_pkg::LENGTH_REG_W-1:0];
                ssf_pkg::CFG_CASE_EXACT:     case_exact_reg     <= cfg_data[0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // Clamp an oversized length to the chain size
    assign len_eff = (pattern_length_reg > ssf_pkg::LENGTH_REG_W'(PATTERN_MAX))
                     ? LEN_W'(PATTERN_MAX) : LEN_W'(pattern_length_reg);
    assign len_zero = (len_eff == '0);

    // ------------------------------------------------------------------
    // Handshake: a new byte is taken whenever the output slot is free or
    // is being drained in the same cycle
    // ------------------------------------------------------------------
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Advance the chain only while searching a non-empty pattern; clear
    // it after the last byte of a text
    assign cell_ctrl.advance    = accept && !found_reg && !len_zero;
    assign cell_ctrl.clear      = accept && s_text_last;
    assign cell_ctrl.case_exact = case_exact_reg;
    assign cell_ctrl.text_char  = ssf_pkg::fold_char(s_text_char, case_exact_reg);

    // ------------------------------------------------------------------
    // Cell chain: cell 0 always sees a matched empty prefix
    // ------------------------------------------------------------------
    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
            assign cell_active[k] = (LEN_W'(k) < len_eff);
            ssf_cell u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .ctrl         (cell_ctrl),
                .active       (cell_active[k]),
                .pattern_char (pattern_bytes_reg[ssf_pkg::CHAR_W*k +: ssf_pkg::CHAR_W]),
                .prev_match   ((k == 0) ? 1'b1 : partial_reg[(k == 0) ? 0 : k-1]),
                .match_next   (partial_next[k]),
                .match_reg    (partial_reg[k])
            );
        end
    endgenerate

    // Pick the bit of the last pattern byte
    always_comb begin
        tail_hit = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (LEN_W'(i + 1) == len_eff) begin
                tail_hit = partial_next[i];
            end
        end
    end

    assign pos_sat = &pos_reg;

    // Match start: current position minus pattern length plus one
    assign start_pos = pos_reg - POSITION_BITS'(len_eff) + POSITION_BITS'(1);
    assign start_ext = {{ssf_pkg::MATCH_START_W{1'b0}}, start_pos};

    // ------------------------------------------------------------------
    // Search state and result
    // ------------------------------------------------------------------
    always_comb begin
        hit          = accept && !found_reg && (len_zero || (tail_hit && !pos_sat));
        emit         = hit || (accept && s_text_last && !found_reg);
        pos_next     = pos_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg;

        if (accept) begin
            if (!pos_sat) begin
                pos_next = pos_reg + POSITION_BITS'(1);
            end
            if (hit) begin
                found_next = 1'b1;
            end
            // End of text: restart position and found flag
            if (s_text_last) begin
                pos_next   = '0;
                found_next = 1'b0;
            end
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload: load with each new result word
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_match_found_reg <= hit;
            m_match_start_reg <= (hit && !len_zero)
                                 ? start_ext[ssf_pkg::MATCH_START_W-1:0] : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match_found = m_match_found_reg;
    assign m_match_start = m_match_start_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The last byte of a text leaves the search state fully cleared
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_text_last) |=> (pos_reg == '0) && (partial_reg == '0) && !found_reg)
        else $error("state not cleared after last text byte");

    // Once the match is reported, the chain stays frozen for the text
    a_frozen_after_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (found_reg && !(accept && s_text_last)) |=> $stable(partial_reg))
        else $error("partial matches changed after match was found");

    // A not-found word follows only the last byte of a text
    a_notfound_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_text_last) |=> (!m_valid_reg || m_match_found_reg))
        else $error("not-found result without last byte");

    // Within a text the position never moves backward
    a_pos_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_text_last) |=> (pos_reg >= $past(pos_reg)) && (pos_reg != '0))
        else $error("text position went backward");

endmodule

### sim/ssf_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_search_checker: result predictor and checker for the substring finder
// Watches the configuration, text and result channels. Keeps its own copy of
// the pattern registers and of the search state, predicts the result of each
// accepted text word and compares every accepted result word in order.
// ----------------------------------------------------------------------------
module ssf_search_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [ssf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ssf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [ssf_pkg::CHAR_W-1:0]          s_text_char,
    input  logic                                s_text_last,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_match_found,
    input  logic [ssf_pkg::MATCH_START_W-1:0]   m_match_start,
    output int                                  mismatch_count,
    output int                                  open_results,
    output int                                  searched_chars
);

    localparam int PMAX = ssf_pkg::PATTERN_MAX_DEF;
    localparam logic [ssf_pkg::MATCH_START_W-1:0] POS_LIMIT = '1;

    typedef struct packed {
        logic                              found;
        logic [ssf_pkg::MATCH_START_W-1:0] start;
    } search_result_t;

    search_result_t expected_q[$];

    logic [ssf_pkg::CFG_DATA_W-1:0]    pat_bytes;
    logic [ssf_pkg::LENGTH_REG_W-1:0]  pat_len;
    logic                              exact_cmp;
    logic [PMAX-1:0]                   partial_vec;
    logic [ssf_pkg::MATCH_START_W-1:0] text_pos;
    logic                              match_seen;

    initial begin
        mismatch_count = 0;
        open_results   = 0;
        searched_chars = 0;
    end

    function automatic logic [7:0] fold_ascii(input logic [7:0] c, input logic exact);
        if (!exact && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 100) begin
            $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
        end
        mismatch_count++;
    endtask

    task automatic clear_search();
        partial_vec = '0;
        text_pos    = '0;
        match_seen  = 1'b0;
    endtask

    // Append one predicted result word at the tail of the queue.
    task automatic queue_result(input logic found,
                                input logic [ssf_pkg::MATCH_START_W-1:0] start);
        search_result_t res;
        res.found = found;
        res.start = start;
        expected_q.insert(expected_q.size(), res);
    endtask

    // Shift-and update for one text byte; queue the result it causes, if any.
    task automatic search_step(input logic [7:0] c, input logic last);
        int                                len;
        logic [PMAX-1:0]                   nv;
        logic [7:0]                        fc;
        logic                              hit;
        logic [ssf_pkg::MATCH_START_W-1:0] start;
        len   = (pat_len > PMAX) ? PMAX : int'(pat_len);
        hit   = 1'b0;
        start = '0;
        searched_chars++;
        if (!match_seen) begin
            if (len == 0) begin
                hit = 1'b1;
            end else begin
                nv = '0;
                fc = fold_ascii(c, exact_cmp);
                for (int k = 0; k < len; k++) begin
                    if ((k == 0 || partial_vec[k-1]) &&
                        fold_ascii(pat_bytes[8*k +: 8], exact_cmp) == fc) begin
                        nv[k] = 1'b1;
                    end
                end
                partial_vec = nv;
                if (nv[len-1] && text_pos != POS_LIMIT) begin
                    hit   = 1'b1;
                    start = text_pos - ssf_pkg::MATCH_START_W'(len - 1);
                end
            end
        end
        if (hit) begin
            queue_result(1'b1, start);
            match_seen = 1'b1;
        end
        if (text_pos != POS_LIMIT) begin
            text_pos++;
        end
        if (last) begin
            if (!match_seen) begin
                queue_result(1'b0, '0);
            end
            clear_search();
        end
    endtask

    always @(posedge aclk) begin
        search_result_t want;
        if (!aresetn) begin
            pat_bytes = '0;
            pat_len   = '0;
            exact_cmp = 1'b1;
            clear_search();
            expected_q.delete();
        end else begin
            // Check first: a result never comes from the word taken at this edge.
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result word with nothing pending", m_match_start, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_match_found !== want.found) begin
                        report_mismatch("match_found", m_match_found, want.found);
                    end
                    if (m_match_start !== want.start) begin
                        report_mismatch("match_start", m_match_start, want.start);
                    end
                end
            end
            if (s_valid && s_ready) begin
                search_step(s_text_char, s_text_last);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ssf_pkg::CFG_PATTERN_BYTES:  pat_bytes = cfg_data;
                    ssf_pkg::CFG_PATTERN_LENGTH: pat_len   = cfg_data[ssf_pkg::LENGTH_REG_W-1:0];
                    ssf_pkg::CFG_CASE_EXACT:     exact_cmp = cfg_data[0];
                    default: ;
                endcase
            end
        end
        open_results = expected_q.size();
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level of the substring finder testbench
// Drives text words and register writes into the block, stalls the result
// channel on its own pattern and leaves prediction and comparison to the
// checker beside it. A short directed pass covers the empty pattern,
// overlapping prefixes, case folding, an oversized length and a write in the
// middle of a text; random texts with planted patterns under many register
// settings follow.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 1550;

    // Index that selects no register; a write there must change nothing.
    localparam logic [ssf_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    // Letters in both cases plus the neighbors of the A..Z and a..z ranges.
    localparam logic [63:0] ALPHABET = "abAB@[`{";

    logic                                aclk;
    logic                                aresetn       = 1'b0;
    logic                                cfg_valid     = 1'b0;
    logic                                cfg_ready;
    logic [ssf_pkg::CFG_INDEX_W-1:0]     cfg_index     = '0;
    logic [ssf_pkg::CFG_DATA_W-1:0]      cfg_data      = '0;
    logic                                s_valid       = 1'b0;
    logic                                s_ready;
    logic [ssf_pkg::CHAR_W-1:0]          s_text_char   = '0;
    logic                                s_text_last   = 1'b0;
    logic                                m_valid;
    logic                                m_ready       = 1'b0;
    logic                                m_match_found;
    logic [ssf_pkg::MATCH_START_W-1:0]   m_match_start;

    int mismatch_count;
    int open_results;
    int searched_chars;

    int          cycles     = 0;
    int          burst_left = 0;
    int          gap_max    = 4;
    logic [15:0] ready_mask = '1;

    // Copy of the registers as last written, used only to shape the text.
    logic [63:0] cur_pat   = '0;
    logic [3:0]  cur_len   = '0;
    logic        cur_exact = 1'b1;

    streaming_substring_finder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_char   (s_text_char),
        .s_text_last   (s_text_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_found (m_match_found),
        .m_match_start (m_match_start)
    );

    ssf_search_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_char    (s_text_char),
        .s_text_last    (s_text_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_found  (m_match_found),
        .m_match_start  (m_match_start),
        .mismatch_count (mismatch_count),
        .open_results   (open_results),
        .searched_chars (searched_chars)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Stop a hung run: nothing correct takes this long.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver stalls: m_ready follows a random 16-bit ready mask that is picked anew.
    // Some patterns are all ones, so long stretches run without stalls.
    always @(negedge aclk) begin
        if (cycles % 128 == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_mask <= '1;
                1:       ready_mask <= 16'($urandom) | 16'h0001;
                2:       ready_mask <= 16'h0001 << $urandom_range(0, 15);
                default: ready_mask <= 16'($urandom) | 16'h8001;
            endcase
        end
        m_ready <= ready_mask[cycles % 16];
    end

    // Flip the case of a letter half of the time; leave other bytes alone.
    function automatic logic [7:0] vary_case(input logic [7:0] c);
        logic [7:0] lower;
        lower = c | 8'h20;
        if (lower >= 8'h61 && lower <= 8'h7A && $urandom_range(0, 1) == 1) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // Present one text word and hold it until it is taken. Words go out in
    // bursts of random length; a random gap may open before each burst.
    task automatic put_char(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, gap_max);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_text_char <= c;
        s_text_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    // Drop valid and hold off until every pending result has come out, then
    // wait out a word still in flight that gives no result.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (open_results != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [ssf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ssf_pkg::CFG_DATA_W-1:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int          base;
        int          n;
        int          plant_at;
        int          len_eff;
        int          r;
        bit          first;
        logic [7:0]  b;
        logic [63:0] pat;
        logic [3:0]  plen;
        logic        exact;
        logic [63:0] d;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        // Empty pattern after reset: first byte reports a match at 0, the
        // last byte after a match gives nothing and clears.
        put_char(8'h78, 1'b0);
        put_char(8'h79, 1'b1);
        // Empty pattern on a one-byte text: match on the last byte only.
        put_char(8'h7A, 1'b1);
        drain_results();

        // Pattern "aab" on "aaab": the overlapping candidate must survive,
        // match starts at 1 and completes on the last byte.
        write_reg(ssf_pkg::CFG_PATTERN_BYTES, 64'h0000_0000_0062_6161);
        write_reg(ssf_pkg::CFG_PATTERN_LENGTH, 64'd3);
        put_char(8'h61, 1'b0);
        put_char(8'h61, 1'b0);
        put_char(8'h61, 1'b0);
        put_char(8'h62, 1'b1);
        // "AAB" under exact compare: not found.
        put_char(8'h41, 1'b0);
        put_char(8'h41, 1'b0);
        put_char(8'h42, 1'b1);
        drain_results();

        // Same text with folding: found at 0.
        write_reg(ssf_pkg::CFG_CASE_EXACT, 64'd0);
        put_char(8'h41, 1'b0);
        put_char(8'h41, 1'b0);
        put_char(8'h42, 1'b1);

        // Write in the middle of a text: one "a" seen, then shorten the
        // pattern to "aa"; the kept partial match completes at 0.
        put_char(8'h61, 1'b0);
        drain_results();
        write_reg(ssf_pkg::CFG_PATTERN_LENGTH, 64'd2);
        put_char(8'h61, 1'b0);
        put_char(8'h62, 1'b1);
        drain_results();

        // Oversized length acts as eight; all-ones pattern on eight 0xFF.
        write_reg(ssf_pkg::CFG_PATTERN_BYTES, '1);
        write_reg(ssf_pkg::CFG_PATTERN_LENGTH, 64'd15);
        write_reg(ssf_pkg::CFG_CASE_EXACT, 64'd1);
        for (int i = 0; i < 8; i++) begin
            put_char(8'hFF, i == 7);
        end
        drain_results();

        // ---- random part ----
        // Each phase: wait for the block to go idle, write a new setting,
        // then send a handful of texts, most with the pattern planted.
        base  = searched_chars;
        first = 1'b1;
        while (searched_chars - base < RANDOM_ITEMS) begin
            drain_results();
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 12;
            endcase

            case ($urandom_range(0, 4))
                0: pat = {$urandom, $urandom};
                1: pat = '1;
                2: pat = '0;
                default: begin
                    for (int i = 0; i < 8; i++) begin
                        pat[8*i +: 8] = vary_case(ALPHABET[8*$urandom_range(0, 7) +: 8]);
                    end
                end
            endcase
            r = $urandom_range(0, 15);
            if (r == 0) begin
                plen = 4'd0;
            end else if (r == 1) begin
                plen = 4'($urandom_range(9, 15));
            end else if (r == 2) begin
                plen = 4'd8;
            end else begin
                plen = 4'($urandom_range(1, 8));
            end
            exact = 1'($urandom_range(0, 1));

            // Unused upper bits of the small registers carry junk at times.
            if (first || $urandom_range(0, 3) != 0) begin
                write_reg(ssf_pkg::CFG_PATTERN_BYTES, pat);
                cur_pat = pat;
            end
            if (first || $urandom_range(0, 3) != 0) begin
                d      = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
                d[3:0] = plen;
                write_reg(ssf_pkg::CFG_PATTERN_LENGTH, d);
                cur_len = plen;
            end
            if (first || $urandom_range(0, 3) != 0) begin
                d    = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
                d[0] = exact;
                write_reg(ssf_pkg::CFG_CASE_EXACT, d);
                cur_exact = exact;
            end
            if ($urandom_range(0, 15) == 0) begin
                write_reg(CFG_SPARE_INDEX, {$urandom, $urandom});
            end
            first   = 1'b0;
            len_eff = (cur_len > 8) ? 8 : int'(cur_len);

            repeat ($urandom_range(2, 8)) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    n = 1;
                end else if (r < 15) begin
                    n = $urandom_range(2, 24);
                end else begin
                    n = $urandom_range(25, 80);
                end
                // Plant the pattern in two texts of three; it may be cut
                // short by the end of the text.
                plant_at = (len_eff > 0 && $urandom_range(0, 2) != 0) ?
                           int'($urandom_range(0, n - 1)) : -1;
                for (int i = 0; i < n; i++) begin
                    if (plant_at >= 0 && i >= plant_at && i < plant_at + len_eff) begin
                        b = cur_pat[8*(i - plant_at) +: 8];
                        if (!cur_exact) begin
                            b = vary_case(b);
                        end
                    end else begin
                        // Noise leans on pattern bytes to build partial matches.
                        case ($urandom_range(0, 3))
                            0, 1:    b = vary_case(cur_pat[8*$urandom_range(0, 7) +: 8]);
                            2:       b = ALPHABET[8*$urandom_range(0, 7) +: 8];
                            default: b = 8'($urandom);
                        endcase
                    end
                    put_char(b, i == n - 1);
                end
            end
        end

        drain_results();
        repeat (10) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
